/* src/shared_buffer_multi_queue_macros.svh */
// Assertion macros shared by the queue store RTL.
`ifndef SHARED_BUFFER_MULTI_QUEUE_MACROS_SVH
`define SHARED_BUFFER_MULTI_QUEUE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SBMQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("queue store check failed");

// Next-cycle implication, checked out of reset.
`define SBMQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("queue store check failed");

`endif

/* src/sbmq_pkg.sv */
// Types and constants of the shared-buffer multi-queue.
package sbmq_pkg;

  localparam int SLOTS      = 16;
  localparam int NUM_QUEUES = 4;
  localparam int DATA_WIDTH = 32;

  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int QUEUE_W  = 2;
  localparam int OUT_W    = 32;
  localparam int STATUS_W = 2;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] idx;
  } ptr_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

endpackage

/* src/shared_buffer_multi_queue.sv */
// Top level: several FIFO queues chained through one shared slot store.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  in      | input     | in_valid / in_ready  | in_mode, in_queue_index, in_push_data
//  out     | output    | out_valid / out_ready| out_pop_data, out_status
//
// In each transaction the accept cycle reads the link and data memories at the selected slot,
// then the S_EXEC state writes back pointers and loads the result register.
// One transaction is in flight at a time; the link memory's read-then-write sets the rate.
// Reset takes effect at once: link entries read as their initial chain via per-slot valid
// bits, so no clearing pass runs. A stalled result holds the block in its write-back cycle.
`include "shared_buffer_multi_queue_macros.svh"

module shared_buffer_multi_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_mode,
  input  logic [sbmq_pkg::QUEUE_W-1:0]        in_queue_index,
  input  logic signed [sbmq_pkg::OUT_W-1:0]   in_push_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sbmq_pkg::OUT_W-1:0]   out_pop_data,
  output logic [sbmq_pkg::STATUS_W-1:0]       out_status
);

  localparam int SLOTS      = sbmq_pkg::SLOTS;
  localparam int NUM_QUEUES = sbmq_pkg::NUM_QUEUES;
  localparam int DATA_WIDTH = sbmq_pkg::DATA_WIDTH;
  localparam int SLOT_W     = sbmq_pkg::SLOT_W;
  localparam int QUEUE_W    = sbmq_pkg::QUEUE_W;
  localparam int OUT_W      = sbmq_pkg::OUT_W;

  // Memories
  logic [DATA_WIDTH-1:0] data_mem [SLOTS];
  sbmq_pkg::ptr_t        link_mem [SLOTS];
  logic [SLOTS-1:0]      link_vld_r;

  // Control and pointer registers
  sbmq_pkg::state_t  state_r, state_nxt;
  sbmq_pkg::ptr_t    head_r [NUM_QUEUES];
  logic [SLOT_W-1:0] tail_r [NUM_QUEUES];
  sbmq_pkg::ptr_t    free_head_r;

  // Latched transaction
  logic                  mode_r;
  logic [QUEUE_W-1:0]    q_r;
  logic [DATA_WIDTH-1:0] wdata_r;
  logic [SLOT_W-1:0]     slot_r;
  logic                  fail_r;

  // Memory read side
  sbmq_pkg::ptr_t        link_rd_r;
  logic                  link_rd_vld_r;
  logic [DATA_WIDTH-1:0] data_rd_r;
  sbmq_pkg::ptr_t        link_rd;
  logic [SLOT_W:0]       next_slot;

  // Result register
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]        out_pop_data_r;
  sbmq_pkg::status_t       out_status_r;

  logic              accept;
  logic              commit;
  logic              q_ok;
  logic [SLOT_W-1:0] acc_slot;
  logic              acc_fail;

  logic              link_we;
  logic [SLOT_W-1:0] link_wa;
  sbmq_pkg::ptr_t    link_wd;
  logic              data_we;

  assign in_ready     = (state_r == sbmq_pkg::S_IDLE);
  assign accept       = in_valid && in_ready;
  assign out_valid    = out_valid_r;
  assign out_pop_data = out_pop_data_r;
  assign out_status   = out_status_r;

  // Decide slot and refusal from current pointers at accept
  always_comb begin
    q_ok = ({1'b0, in_queue_index} < (QUEUE_W+1)'(NUM_QUEUES));
    if (in_mode == sbmq_pkg::MODE_PUSH) begin
      acc_slot = free_head_r.idx;
      acc_fail = !q_ok || !free_head_r.valid;
    end else begin
      acc_slot = head_r[in_queue_index].idx;
      acc_fail = !q_ok || !head_r[in_queue_index].valid;
    end
  end

  // Untouched link entries read as the initial chain: slot i links i+1, last is null
  always_comb begin
    next_slot = {1'b0, slot_r} + (SLOT_W+1)'(1);
    if (link_rd_vld_r) begin
      link_rd = link_rd_r;
    end else begin
      link_rd.valid = (next_slot < (SLOT_W+1)'(SLOTS));
      link_rd.idx   = link_rd.valid ? next_slot[SLOT_W-1:0] : '0;
    end
  end

  // Next state, write-back enables and result
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    commit        = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      sbmq_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = sbmq_pkg::S_EXEC;
        end
      end
      sbmq_pkg::S_EXEC: begin
        // Hold until the result register is free
        if (!out_valid_r || out_ready) begin
          commit        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = sbmq_pkg::S_IDLE;
        end
      end
      default: state_nxt = sbmq_pkg::S_IDLE;
    endcase

    link_we = 1'b0;
    link_wa = slot_r;
    link_wd = free_head_r;
    data_we = 1'b0;
    if (commit && !fail_r) begin
      if (mode_r == sbmq_pkg::MODE_PUSH) begin
        data_we = 1'b1;
        if (head_r[q_r].valid) begin
          link_we       = 1'b1;
          link_wa       = tail_r[q_r];
          link_wd.valid = 1'b1;
          link_wd.idx   = slot_r;
        end
      end else begin
        link_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= sbmq_pkg::S_IDLE;
      out_valid_r       <= 1'b0;
      free_head_r.valid <= 1'b1;
      free_head_r.idx   <= '0;
      link_vld_r        <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (link_we) begin
        link_vld_r[link_wa] <= 1'b1;
      end
      if (commit && !fail_r) begin
        if (mode_r == sbmq_pkg::MODE_PUSH) begin
          free_head_r <= link_rd;
          if (!head_r[q_r].valid) begin
            head_r[q_r].valid <= 1'b1;
            head_r[q_r].idx   <= slot_r;
          end
        end else begin
          free_head_r.valid <= 1'b1;
          free_head_r.idx   <= slot_r;
          // The tail slot's link is stale; popping it empties the queue
          if (slot_r == tail_r[q_r]) begin
            head_r[q_r] <= '0;
          end else begin
            head_r[q_r] <= link_rd;
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r        <= in_mode;
      q_r           <= in_queue_index;
      wdata_r       <= DATA_WIDTH'(in_push_data);
      slot_r        <= acc_slot;
      fail_r        <= acc_fail;
      link_rd_vld_r <= link_vld_r[acc_slot];
    end
    if (commit && !fail_r && mode_r == sbmq_pkg::MODE_PUSH) begin
      tail_r[q_r] <= slot_r;
    end
    if (commit) begin
      if (fail_r) begin
        out_pop_data_r <= '0;
        out_status_r   <= (mode_r == sbmq_pkg::MODE_PUSH) ? sbmq_pkg::ST_FULL
                                                           : sbmq_pkg::ST_EMPTY;
      end else begin
        out_pop_data_r <= (mode_r == sbmq_pkg::MODE_PUSH) ? '0 : OUT_W'(data_rd_r);
        out_status_r   <= sbmq_pkg::ST_OK;
      end
    end
  end

  // Link memory
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (accept) begin
      link_rd_r <= link_mem[acc_slot];
    end
  end

  // Data memory
  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[slot_r] <= wdata_r;
    end
    if (accept) begin
      data_rd_r <= data_mem[acc_slot];
    end
  end

  `SBMQ_ASSERT_NEXT(a_accept_to_exec, accept, state_r == sbmq_pkg::S_EXEC)
  `SBMQ_ASSERT_NEXT(a_stall_holds_exec,
                    state_r == sbmq_pkg::S_EXEC && out_valid_r && !out_ready,
                    state_r == sbmq_pkg::S_EXEC && out_valid_r)
  `SBMQ_ASSERT_NOW(a_push_has_free_slot,
                   commit && !fail_r && mode_r == sbmq_pkg::MODE_PUSH,
                   free_head_r.valid)
  `SBMQ_ASSERT_NOW(a_refused_zero_data,
                   out_valid_r && out_status_r != sbmq_pkg::ST_OK,
                   out_pop_data_r == '0)

endmodule
